// File: rtl/core/assert_macros.svh
// Assertion macros for the RTL file that carries concurrent checks.
// Depends on nothing; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define CHBM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge out of reset
`define CHBM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/core/chbm_pkg.sv
// Shared types, constants and helper functions of the bucket map.
// Depends on nothing; used by every module of the block.
package chbm_pkg;

  localparam int WORD_W  = 64;
  localparam int GNOW_W  = 17;
  localparam int DIV_W   = 18;
  localparam int SLOG_W  = 5;
  localparam int TZ_W    = 6;

  localparam int ROT_A   = 55;
  localparam int SHIFT_B = 14;
  localparam int ROT_B   = 36;
  localparam logic [WORD_W-1:0] HASH_MASK = 64'h0FFF_FFFF_FFFF_FFFF;

  // last trailing-zero count that still leaves a usable shift
  localparam logic [TZ_W-1:0] TZ_LAST = 6'd62;

  localparam logic [15:0] GROUP_SIZE_RST = 16'd16;

  // configuration register indexes
  localparam logic [1:0] CFG_GROUP_SIZE = 2'd0;
  localparam logic [1:0] CFG_HASH_SEED  = 2'd1;
  localparam logic [1:0] CFG_PREHASHED  = 2'd2;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_DEL    = 2'd2,
    REQ_INIT   = 2'd3
  } req_t;

  // command to the arc state store
  typedef struct packed {
    logic en;
    req_t kind;
  } arc_cmd_t;

  // seeded xorshift-rotate key mix, masked to 60 bits
  function automatic logic [WORD_W-1:0] mix_key(input logic [WORD_W-1:0] key,
                                                 input logic [WORD_W-1:0] seed);
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] a2;
    logic [WORD_W-1:0] b2;
    b  = seed ^ key;
    a2 = ((key << ROT_A) | (key >> (WORD_W - ROT_A))) ^ b ^ (b << SHIFT_B);
    b2 = (b << ROT_B) | (b >> (WORD_W - ROT_B));
    return (a2 + b2) & HASH_MASK;
  endfunction

  // ceiling of log2 of the group size
  function automatic logic [SLOG_W-1:0] ceil_log2(input logic [15:0] s);
    logic [SLOG_W-1:0] c;
    c = '0;
    for (int k = 0; k < 16; k++) begin
      if ((17'd1 << k) < {1'b0, s}) c = c + SLOG_W'(1);
    end
    return c;
  endfunction

endpackage

// File: rtl/core/consistent_hash_bucket_map_unit.sv
// Consistent-hash bucket map: sequencer, configuration and result register.
// Add, delete, reinit: the request goes through S_UPD to S_OUT, where the result beat is registered.
// Lookup: its run time is set by the bit-serial multiplier (one cycle
// per multiplier bit, up to eleven products), the 64-step divider and the zero shift.
// One item in work at a time; an output stall holds it in S_OUT. Reset restores group size 16,
// seed 0, hashing on, both versions to one bucket. Uses chbm_pkg, chbm_arcs/mul/div.
`include "assert_macros.svh"

module consistent_hash_bucket_map_unit #(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic        in_version_sel,
  input  logic [63:0] in_key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_bucket,
  output logic [31:0] out_bucket_count,
  output logic        out_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import chbm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_UPD, S_ARC0, S_DMUL, S_SCI, S_SCW, S_ARC1,
    S_BKT0, S_DIVW, S_BKT1, S_RMULW, S_TZ, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    RET_ARC, RET_ARC1, RET_ARC2
  } ret_t;

  state_t            state_r;
  ret_t              ret_r;
  logic [15:0]       gsize_r;
  logic [WORD_W-1:0] seed_r;
  logic              prehashed_r;
  req_t              req_r;
  logic              ver_r;
  logic [WORD_W-1:0] h_r;
  logic [WORD_W-1:0] d_r;
  logic [WORD_W-1:0] t_r;
  logic [WORD_W-1:0] arc_r;
  logic [WORD_W-1:0] grp_r;
  logic [WORD_W-1:0] res_r;
  logic [DIV_W-1:0]  div_r;
  logic [TZ_W-1:0]   cnt_r;
  logic [1:0]        ph_r;
  logic              dsel_r;
  logic [31:0]       bucket_r;
  logic              err_r;
  logic              out_valid_r;
  logic [31:0]       out_bucket_r;
  logic [31:0]       out_count_r;
  logic              out_error_r;

  arc_cmd_t              cmd;
  logic [COUNT_BITS:0]   total;
  logic [COUNT_BITS-1:0] sa, sg, gc;
  logic [GNOW_W-1:0]     gn;
  logic                  arc_err;

  logic [15:0]       s_eff;
  logic [SLOG_W-1:0] slog;
  logic [WORD_W-1:0] s64, sa64, sg64, gn64, gc64, n64;

  logic              mul_start, mul_done;
  logic [WORD_W-1:0] mul_a, mul_b, mul_p;
  logic              div_start, div_done;
  logic [WORD_W-1:0] div_n, div_q;
  logic [DIV_W-1:0]  div_d, div_rem;

  logic [WORD_W-1:0] sc_sum;
  logic              div_gt;
  logic [WORD_W-1:0] init_v, grp_v;
  logic [DIV_W-1:0]  pos_v;
  logic              grp_zero;

  // effective group size and widened counters
  assign s_eff = (gsize_r == '0) ? 16'd1 : gsize_r;
  assign slog  = ceil_log2(s_eff);
  assign s64   = 64'(s_eff);
  assign sa64  = 64'(sa);
  assign sg64  = 64'(sg);
  assign gn64  = 64'(gn);
  assign gc64  = 64'(gc);
  assign n64   = 64'(total);

  assign cmd = {state_r == S_UPD, req_r};

  chbm_arcs #(.CB(COUNT_BITS)) u_arcs (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .ver          (ver_r),
    .s            (s_eff),
    .total        (total),
    .short_cnt    (sa),
    .short_groups (sg),
    .group_now    (gn),
    .group_count  (gc),
    .err          (arc_err)
  );

  chbm_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  chbm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .n     (div_n),
    .d     (div_d),
    .done  (div_done),
    .quot  (div_q),
    .rem   (div_rem)
  );

  // group/position fix-up after the division
  assign div_gt   = div_r > {2'b00, s_eff};
  assign init_v   = div_gt ? {gc64[WORD_W-2:0], 1'b0} : gc64;
  assign grp_v    = (div_r == '0) ? '0 :
                    div_gt ? {div_q[WORD_W-2:0], 1'b0} + 64'(div_rem >> slog) : div_q;
  assign pos_v    = div_gt ? (div_rem & DIV_W'(s_eff - 16'd1)) : div_rem;
  assign grp_zero = (grp_v == '0);

  // partial-product sum of the split high product
  assign sc_sum = (ph_r == 2'd3) ? mul_p + (t_r >> 32) : t_r + mul_p;

  // multiplier and divider issue
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_n     = (sa64 <= arc_r) ? arc_r - sg64 : arc_r;
    div_d     = DIV_W'(gn) + DIV_W'(sa64 > arc_r);
    case (state_r)
      S_ARC0: begin
        mul_start = (n64 >= s64);
        mul_a     = gc64;
        mul_b     = gn64 + 64'd1;
      end
      S_ARC1: begin
        mul_start = (arc_r >= sa64);
        mul_a     = gc64;
        mul_b     = gn64;
      end
      S_SCI: begin
        mul_start = 1'b1;
        mul_a     = (ph_r[0]) ? {32'd0, h_r[63:32]} : {32'd0, h_r[31:0]};
        mul_b     = (ph_r[1]) ? {32'd0, d_r[63:32]} : {32'd0, d_r[31:0]};
      end
      S_BKT0: begin
        div_start = (arc_r >= s64);
      end
      S_BKT1: begin
        mul_start = !grp_zero;
        mul_a     = init_v;
        mul_b     = s64 + 64'(pos_v);
      end
      default: begin
      end
    endcase
  end

  // sequencer, configuration and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gsize_r     <= GROUP_SIZE_RST;
      seed_r      <= '0;
      prehashed_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_GROUP_SIZE: gsize_r     <= cfg_data[15:0];
          CFG_HASH_SEED:  seed_r      <= cfg_data;
          CFG_PREHASHED:  prehashed_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (out_valid_r && !out_stall && state_r != S_OUT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r    <= req_t'(in_req_type);
            ver_r    <= in_version_sel;
            h_r      <= prehashed_r ? in_key : mix_key(in_key, seed_r);
            bucket_r <= '0;
            err_r    <= 1'b0;
            state_r  <= (req_t'(in_req_type) == REQ_LOOKUP) ? S_ARC0 : S_UPD;
          end
        end
        S_UPD: begin
          err_r   <= arc_err;
          state_r <= S_OUT;
        end
        S_ARC0: begin
          if (n64 < s64) begin
            d_r     <= n64;
            ret_r   <= RET_ARC;
            ph_r    <= 2'd0;
            state_r <= S_SCI;
          end else begin
            dsel_r  <= 1'b0;
            state_r <= S_DMUL;
          end
        end
        S_DMUL: begin
          if (mul_done) begin
            d_r     <= mul_p;
            ret_r   <= dsel_r ? RET_ARC2 : RET_ARC1;
            ph_r    <= 2'd0;
            state_r <= S_SCI;
          end
        end
        S_SCI: begin
          state_r <= S_SCW;
        end
        S_SCW: begin
          if (mul_done) begin
            if (ph_r == 2'd0) begin
              t_r <= mul_p >> 32;
            end else begin
              t_r <= sc_sum;
            end
            if (ph_r != 2'd3) begin
              ph_r    <= ph_r + 2'd1;
              state_r <= S_SCI;
            end else begin
              case (ret_r)
                RET_ARC: begin
                  arc_r   <= sc_sum;
                  state_r <= S_BKT0;
                end
                RET_ARC1: begin
                  arc_r   <= sc_sum;
                  state_r <= S_ARC1;
                end
                default: begin
                  arc_r   <= sc_sum + sg64;
                  state_r <= S_BKT0;
                end
              endcase
            end
          end
        end
        S_ARC1: begin
          if (arc_r < sa64) begin
            state_r <= S_BKT0;
          end else begin
            dsel_r  <= 1'b1;
            state_r <= S_DMUL;
          end
        end
        S_BKT0: begin
          if (arc_r < s64) begin
            bucket_r <= arc_r[31:0];
            state_r  <= S_OUT;
          end else begin
            div_r   <= div_d;
            state_r <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (div_done) state_r <= S_BKT1;
        end
        S_BKT1: begin
          grp_r   <= grp_v;
          state_r <= grp_zero ? S_OUT : S_RMULW;
        end
        S_RMULW: begin
          if (mul_done) begin
            res_r   <= mul_p + grp_r;
            cnt_r   <= '0;
            state_r <= S_TZ;
          end
        end
        S_TZ: begin
          // shift out trailing zeros of the group, then one more place
          if (grp_r[0]) begin
            bucket_r <= res_r[32:1];
            state_r  <= S_OUT;
          end else if (cnt_r == TZ_LAST) begin
            state_r <= S_OUT;
          end else begin
            grp_r <= grp_r >> 1;
            res_r <= res_r >> 1;
            cnt_r <= cnt_r + TZ_W'(1);
          end
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_bucket_r <= bucket_r;
            out_count_r  <= 32'(total);
            out_error_r  <= err_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_bucket       = out_bucket_r;
  assign out_bucket_count = out_count_r;
  assign out_error        = out_error_r;

  // checks
  `CHBM_ASSERT_NEVER(a_err_bucket, clk, rst_n, out_valid && out_error && (out_bucket != 32'd0), "error beat carries a bucket")
  `CHBM_ASSERT(a_mul_wait, clk, rst_n, !mul_done || state_r == S_DMUL || state_r == S_SCW || state_r == S_RMULW, "multiplier finished outside a wait state")
  `CHBM_ASSERT(a_div_wait, clk, rst_n, !div_done || state_r == S_DIVW, "divider finished outside its wait state")

endmodule

// File: rtl/core/chbm_mul.sv
// Bit-serial shift-add multiplier, product modulo 2^64.
// One multiplier bit a cycle, stops once the remaining bits are zero.
// Depends on chbm_pkg.
module chbm_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] prod
);
  import chbm_pkg::*;

  logic [WORD_W-1:0] a_r;
  logic [WORD_W-1:0] b_r;
  logic [WORD_W-1:0] p_r;
  logic              run_r;
  logic              done_r;

  // shift-add step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r   <= a;
        b_r   <= b;
        p_r   <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        if (b_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          if (b_r[0]) p_r <= p_r + a_r;
          a_r <= {a_r[WORD_W-2:0], 1'b0};
          b_r <= {1'b0, b_r[WORD_W-1:1]};
        end
      end
    end
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

// File: rtl/core/chbm_div.sv
// Restoring divider, 64-bit dividend by 18-bit divisor, one bit a cycle.
// 64 steps; quotient and remainder hold after done. Depends on chbm_pkg.
module chbm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] n,
  input  logic [17:0] d,
  output logic        done,
  output logic [63:0] quot,
  output logic [17:0] rem
);
  import chbm_pkg::*;

  logic [WORD_W-1:0] q_r;
  logic [DIV_W-1:0]  d_r;
  logic [DIV_W-1:0]  rem_r;
  logic [TZ_W-1:0]   cnt_r;
  logic              run_r;
  logic              done_r;
  logic [DIV_W:0]    rr;
  logic [DIV_W:0]    diff;
  logic              ge;

  // trial subtract of the shifted remainder
  assign rr   = {rem_r, q_r[WORD_W-1]};
  assign ge   = rr >= {1'b0, d_r};
  assign diff = rr - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r   <= n;
        d_r   <= d;
        rem_r <= '0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= ge ? diff[DIV_W-1:0] : rr[DIV_W-1:0];
        q_r   <= {q_r[WORD_W-2:0], ge};
        cnt_r <= cnt_r + TZ_W'(1);
        if (cnt_r == {TZ_W{1'b1}}) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

// File: rtl/core/chbm_arcs.sv
// Two versions of arc state with in-place add, delete and reinit.
// Presents the selected version's counters. Depends on chbm_pkg.
module chbm_arcs #(
  parameter int CB = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  chbm_pkg::arc_cmd_t        cmd,
  input  logic                      ver,
  input  logic [15:0]               s,
  output logic [CB:0]               total,
  output logic [CB-1:0]             short_cnt,
  output logic [CB-1:0]             short_groups,
  output logic [chbm_pkg::GNOW_W-1:0] group_now,
  output logic [CB-1:0]             group_count,
  output logic                      err
);
  import chbm_pkg::*;

  logic [CB-1:0]     long_r [2];
  logic [CB-1:0]     sa_r   [2];
  logic [CB-1:0]     sg_r   [2];
  logic [GNOW_W-1:0] gn_r   [2];
  logic [CB-1:0]     gc_r   [2];

  logic [CB-1:0]     l_q, sa_q, sg_q, gc_q;
  logic [GNOW_W-1:0] gn_q;
  logic [CB:0]       tot_q;
  logic [CB-1:0]     l_nxt, sa_nxt, sg_nxt, gc_nxt;
  logic [GNOW_W-1:0] gn_nxt;
  logic              wr;

  assign l_q   = long_r[ver];
  assign sa_q  = sa_r[ver];
  assign sg_q  = sg_r[ver];
  assign gn_q  = gn_r[ver];
  assign gc_q  = gc_r[ver];
  assign tot_q = {1'b0, l_q} + {1'b0, sa_q};

  // next version state for the requested change
  always_comb begin
    l_nxt  = l_q;
    sa_nxt = sa_q;
    sg_nxt = sg_q;
    gn_nxt = gn_q;
    gc_nxt = gc_q;
    wr     = 1'b0;
    err    = 1'b0;
    case (cmd.kind)
      REQ_ADD: begin
        if (tot_q >= {1'b0, {CB{1'b1}}}) begin
          err = 1'b1;
        end else begin
          wr = 1'b1;
          if (64'(tot_q) < 64'(s)) begin
            l_nxt = l_q + CB'(1);
          end else begin
            l_nxt  = l_q - CB'(gn_q);
            sg_nxt = sg_q + CB'(1);
            sa_nxt = sa_q + CB'(gn_q) + CB'(1);
            // long arcs used up: short arcs become the long set
            if (l_nxt == '0) begin
              l_nxt  = sa_nxt;
              sg_nxt = '0;
              sa_nxt = '0;
              gn_nxt = gn_q + GNOW_W'(1);
            end
            // group size doubled: halve arcs per group, double groups
            if (gn_nxt == {s, 1'b0}) begin
              gn_nxt = {1'b0, s};
              gc_nxt = {gc_q[CB-2:0], 1'b0};
            end
          end
        end
      end
      REQ_DEL: begin
        if (tot_q == '0) begin
          err = 1'b1;
        end else begin
          wr = 1'b1;
          if (64'(tot_q) <= 64'(s)) begin
            l_nxt = l_q - CB'(1);
          end else begin
            if (gn_q == {1'b0, s} && sa_q == '0) begin
              gn_nxt = {s, 1'b0};
              gc_nxt = {1'b0, gc_q[CB-1:1]};
            end
            if (sa_q == '0) begin
              sa_nxt = l_q;
              sg_nxt = gc_nxt;
              l_nxt  = '0;
              gn_nxt = gn_nxt - GNOW_W'(1);
            end
            sa_nxt = sa_nxt - CB'(gn_nxt) - CB'(1);
            sg_nxt = sg_nxt - CB'(1);
            l_nxt  = l_nxt + CB'(gn_nxt);
          end
        end
      end
      REQ_INIT: begin
        wr     = 1'b1;
        l_nxt  = CB'(1);
        sa_nxt = '0;
        sg_nxt = '0;
        gn_nxt = {1'b0, s};
        gc_nxt = CB'(1);
      end
      default: begin
      end
    endcase
  end

  // version store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < 2; v++) begin
        long_r[v] <= CB'(1);
        sa_r[v]   <= '0;
        sg_r[v]   <= '0;
        gn_r[v]   <= {1'b0, GROUP_SIZE_RST};
        gc_r[v]   <= CB'(1);
      end
    end else if (cmd.en && wr) begin
      long_r[ver] <= l_nxt;
      sa_r[ver]   <= sa_nxt;
      sg_r[ver]   <= sg_nxt;
      gn_r[ver]   <= gn_nxt;
      gc_r[ver]   <= gc_nxt;
    end
  end

  assign total        = tot_q;
  assign short_cnt    = sa_q;
  assign short_groups = sg_q;
  assign group_now    = gn_q;
  assign group_count  = gc_q;

endmodule

// File: sim/tb.sv
// Self-checking bench for consistent_hash_bucket_map_unit: directed and random bursts of requests,
// an independent bucket-map predictor and in-order comparison of every result beat.
// Depends on chbm_pkg and the RTL of the block; nothing else.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import chbm_pkg::*;

  localparam int CB = 32;
  localparam logic [63:0] CNT_FULL = (64'd1 << CB) - 64'd1;

  typedef struct {
    logic [31:0] bucket;
    logic [31:0] bucket_count;
    logic        error;
  } map_result_t;

  int err_count = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // Predictor of the bucket map plus the queue of results still owed
  class bucket_map_board;
    logic [63:0] gsize, seed;
    bit          prehashed;
    logic [63:0] long_cnt[2], short_cnt[2], short_groups[2], grp_now[2], grp_cnt[2];
    map_result_t owed[$];

    function new();
      gsize = 16; seed = 0; prehashed = 0;
      reinit(0); reinit(1);
    endfunction

    function logic [63:0] eff_size();
      return (gsize == 0) ? 64'd1 : gsize;
    endfunction

    function void reinit(int v);
      long_cnt[v] = 1; short_cnt[v] = 0; short_groups[v] = 0;
      grp_now[v] = eff_size() & 64'h1ffff; grp_cnt[v] = 1;
    endfunction

    function void set_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        CFG_GROUP_SIZE: gsize = val & 64'hffff;
        CFG_HASH_SEED:  seed = val;
        CFG_PREHASHED:  prehashed = val[0];
        default: ;
      endcase
    endfunction

    function logic [63:0] hash_key(logic [63:0] k);
      logic [63:0] a, b;
      b = seed ^ k;
      a = {k[8:0], k[63:9]} ^ b ^ (b << 14);
      b = {b[27:0], b[63:28]};
      return (a + b) & 64'h0fff_ffff_ffff_ffff;
    endfunction

    function logic [63:0] high_prod(logic [63:0] d, logic [63:0] h);
      logic [63:0] lo;
      lo = (h[31:0] * d[31:0]) >> 32;
      return h[63:32] * d[63:32] + ((h[63:32] * d[31:0] + h[31:0] * d[63:32] + lo) >> 32);
    endfunction

    function logic [63:0] arcs_total(int v);
      return long_cnt[v] + short_cnt[v];
    endfunction

    function logic [63:0] arc_of(logic [63:0] h, int v);
      logic [63:0] c;
      if (arcs_total(v) < eff_size()) return high_prod(arcs_total(v), h);
      c = high_prod((grp_now[v] + 1) * grp_cnt[v], h);
      if (c < short_cnt[v]) return c;
      return high_prod(grp_now[v] * grp_cnt[v], h) + short_groups[v];
    endfunction

    function logic [63:0] bucket_of(logic [63:0] arc, int v);
      logic [63:0] s, dv, grp, pos, init, r;
      int slog, tz_cnt;
      s = eff_size();
      if (arc < s) return arc;
      slog = 0;
      while (slog < 63 && (64'd1 << slog) < s) slog++;
      dv = grp_now[v] + ((short_cnt[v] > arc) ? 1 : 0);
      if (short_cnt[v] <= arc) arc = arc - short_groups[v];
      if (dv == 0) begin
        grp = 0; pos = arc;
      end else begin
        grp = arc / dv; pos = arc - grp * dv;
      end
      init = grp_cnt[v];
      if (dv > s) begin
        init = init << 1;
        grp = (grp << 1) + (pos >> slog);
        pos = pos & (s - 1);
      end
      if (grp == 0) return 0;
      tz_cnt = 0;
      while (grp[tz_cnt] == 1'b0) tz_cnt++;
      if (tz_cnt + 1 >= 64) return 0;
      r = (s + pos) * init + grp;
      return r >> (tz_cnt + 1);
    endfunction

    function void grow(int v);
      logic [63:0] s;
      s = eff_size();
      if (arcs_total(v) < s) begin
        long_cnt[v] = (long_cnt[v] + 1) & CNT_FULL;
        return;
      end
      long_cnt[v] = (long_cnt[v] - grp_now[v]) & CNT_FULL;
      short_groups[v] = (short_groups[v] + 1) & CNT_FULL;
      short_cnt[v] = (short_cnt[v] + grp_now[v] + 1) & CNT_FULL;
      if (long_cnt[v] == 0) begin
        long_cnt[v] = short_cnt[v]; short_groups[v] = 0; short_cnt[v] = 0;
        grp_now[v] = (grp_now[v] + 1) & 64'h1ffff;
      end
      if (grp_now[v] == 2 * s) begin
        grp_now[v] = s; grp_cnt[v] = (grp_cnt[v] * 2) & CNT_FULL;
      end
    endfunction

    function void shrink(int v);
      logic [63:0] s;
      s = eff_size();
      if (arcs_total(v) <= s) begin
        long_cnt[v] = (long_cnt[v] - 1) & CNT_FULL;
        return;
      end
      if (grp_now[v] == s && short_cnt[v] == 0) begin
        grp_now[v] = (2 * s) & 64'h1ffff; grp_cnt[v] = grp_cnt[v] >> 1;
      end
      if (short_cnt[v] == 0) begin
        short_cnt[v] = long_cnt[v]; short_groups[v] = grp_cnt[v]; long_cnt[v] = 0;
        grp_now[v] = (grp_now[v] - 1) & 64'h1ffff;
      end
      short_cnt[v] = (short_cnt[v] - (grp_now[v] + 1)) & CNT_FULL;
      short_groups[v] = (short_groups[v] - 1) & CNT_FULL;
      long_cnt[v] = (long_cnt[v] + grp_now[v]) & CNT_FULL;
    endfunction

    // note an accepted request beat and queue the result it owes
    function void note_request(req_t kind, bit v, logic [63:0] key);
      map_result_t r;
      logic [63:0] h;
      r.bucket = 0; r.error = 0;
      case (kind)
        REQ_LOOKUP: begin
          h = prehashed ? key : hash_key(key);
          r.bucket = bucket_of(arc_of(h, v), v);
        end
        REQ_ADD:  if (arcs_total(v) >= CNT_FULL) r.error = 1; else grow(v);
        REQ_DEL:  if (arcs_total(v) == 0) r.error = 1; else shrink(v);
        default:  reinit(v);
      endcase
      r.bucket_count = arcs_total(v);
      owed.push_back(r);
    endfunction

    // compare one result beat with the oldest owed result
    task check_result(logic [31:0] b, logic [31:0] c, logic e);
      map_result_t w;
      if (owed.size() == 0) begin
        report_mismatch("unexpected beat", b, 0);
        return;
      end
      w = owed.pop_front();
      if (b !== w.bucket) report_mismatch("bucket", b, w.bucket);
      if (c !== w.bucket_count) report_mismatch("bucket_count", c, w.bucket_count);
      if (e !== w.error) report_mismatch("error", e, w.error);
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, in_version_sel = 0;
  logic [1:0] in_req_type = REQ_LOOKUP;
  logic [63:0] in_key = 0;
  logic out_valid, out_stall = 0, out_error;
  logic [31:0] out_bucket, out_bucket_count;
  logic cfg_valid = 0, cfg_ready;
  logic [1:0] cfg_index = CFG_GROUP_SIZE;
  logic [63:0] cfg_data = 0;

  bucket_map_board board = new();

  consistent_hash_bucket_map_unit u_dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // receiver: stall pattern changes mode now and then
  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_bucket, out_bucket_count, out_error);
    if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // one request beat; waits for acceptance
  task automatic send_req(req_t kind, bit v, logic [63:0] key);
    in_valid <= 1'b1; in_req_type <= kind; in_version_sel <= v; in_key <= key;
    do @(posedge clk); while (in_stall);
    board.note_request(kind, v, key);
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_reg(idx, val);
  endtask

  // let every owed result drain, then idle the sender before returning
  task automatic drain();
    in_valid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_key();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return '1;
      2: return {32'd0, $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // weighted request mix; bias tracks whether to grow or shrink
  function automatic req_t rand_req(int grow_bias);
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return REQ_LOOKUP;
    if (r < 40 + grow_bias) return REQ_ADD;
    if (r < 97) return REQ_DEL;
    return REQ_INIT;
  endfunction

  task automatic random_phase(int n, int gmax);
    int left, burst, bias;
    left = n;
    bias = 35;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && left > 0) begin
        if ($urandom_range(0, 49) == 0) bias = $urandom_range(20, 50);
        send_req(rand_req(bias), $urandom_range(0, 1), rand_key());
        burst--; left--;
      end
      idle_sender($urandom_range(0, gmax));
    end
  endtask

  typedef struct {
    logic [15:0] gs;
    logic [63:0] sd;
    bit          ph;
  } cfg_set_t;

  initial begin
    cfg_set_t sets[6];
    sets[0] = '{16'd16, 64'd0, 1'b0};
    sets[1] = '{16'd1, 64'hffff_ffff_ffff_ffff, 1'b0};
    sets[2] = '{16'd0, 64'h0123_4567_89ab_cdef, 1'b1};
    sets[3] = '{16'd32768, 64'h8000_0000_0000_0001, 1'b0};
    sets[4] = '{16'd12, 64'hdead_beef_0000_5555, 1'b1};
    sets[5] = '{16'd4, 64'h5555_aaaa_5555_aaaa, 1'b0};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset state, field extremes, every request kind
    send_req(REQ_LOOKUP, 0, 64'd0);
    send_req(REQ_LOOKUP, 1, '1);
    send_req(REQ_DEL, 0, 0);
    send_req(REQ_DEL, 0, 0);   // delete at zero buckets
    send_req(REQ_LOOKUP, 0, 64'h1234);
    send_req(REQ_ADD, 0, 0);
    for (int i = 0; i < 20; i++) send_req(REQ_ADD, 1, 0);
    send_req(REQ_LOOKUP, 1, 64'hfedc_ba98_7654_3210);
    send_req(REQ_INIT, 1, '1);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_GROUP_SIZE, {48'd0, sets[p].gs});
      write_reg(CFG_HASH_SEED, sets[p].sd);
      write_reg(CFG_PREHASHED, {63'd0, sets[p].ph});
      random_phase(285, (p % 2) ? 0 : 6);
      drain();
    end

    if (err_count == 0) $display("PASS consistent_hash_bucket_map_unit");
    else $display("FAIL consistent_hash_bucket_map_unit");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL consistent_hash_bucket_map_unit");
    $finish;
  end

endmodule

// File: consistent_hash_bucket_map_unit.f
+incdir+rtl/core
rtl/core/chbm_pkg.sv
rtl/core/chbm_mul.sv
rtl/core/chbm_div.sv
rtl/core/chbm_arcs.sv
rtl/core/consistent_hash_bucket_map_unit.sv
sim/tb.sv
